[design/prle_pkg.sv]
package prle_pkg;

  // longest run one pair can carry
  localparam logic [7:0] MaxRun = 8'd255;

  // result queue depth and its index widths
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  // input beat
  typedef struct packed {
    logic [7:0] pixel_color;
    logic       frame_end;
  } pix_in_t;

  // result beat
  typedef struct packed {
    logic [7:0] run_color;
    logic [7:0] run_length;
    logic       frame_done;
    logic       last_result;
  } run_out_t;

  // results of one item handed to the queue, compacted into beat0 first
  typedef struct packed {
    logic [1:0] cnt;
    run_out_t   beat0;
    run_out_t   beat1;
  } push_t;

endpackage

[design/pixel_run_length_encoder.sv]
// channel  | valid       | stall        | payload
// input    | in_valid_i  | in_stall_o   | in_data_i  (prle_pkg::pix_in_t)
// output   | out_valid_o | out_stall_i  | out_data_o (prle_pkg::run_out_t)
// config   | cfg_we_i    | -            | cfg_wdata_i (rle_enable)
//
// one pixel per cycle while the queue has room: a beat is registered, then
// encoded from that register, and its zero, one or two results go into a four-entry result queue
// a result passes the input register and the queue registers before it shows on out_valid_o
// the queue drains one beat per cycle while out_stall_i is low, so an item with two
// results takes two beats of output bandwidth; input stalls when the queue holds
// more than two beats
// reset clears run state and queue and sets rle_enable to 1
module pixel_run_length_encoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  prle_pkg::pix_in_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output prle_pkg::run_out_t  out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i
);

  logic                in_valid_q, in_valid_d;
  prle_pkg::pix_in_t   in_q;
  logic                rle_enable_q;
  logic [7:0]          open_color_q, open_color_d;
  logic [7:0]          open_count_q, open_count_d;
  logic                run_open_q, run_open_d;
  logic                room;
  logic                fire;
  logic                accept;
  logic                same;
  logic                extend;
  logic                emit_old;
  logic                emit_new;
  logic [7:0]          new_color;
  logic [7:0]          new_count;
  prle_pkg::run_out_t  old_beat;
  prle_pkg::run_out_t  new_beat;
  prle_pkg::push_t     push;

  // input handshake
  assign fire       = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rle_enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      rle_enable_q <= cfg_wdata_i;
    end
  end

  // encode the registered pixel against the open run
  always_comb begin
    same      = run_open_q && (in_q.pixel_color == open_color_q) &&
                (open_count_q < prle_pkg::MaxRun);
    extend    = rle_enable_q && same;
    emit_old  = run_open_q && !extend;
    emit_new  = !rle_enable_q || in_q.frame_end;
    new_color = extend ? open_color_q : in_q.pixel_color;
    new_count = extend ? open_count_q + 8'd1 : 8'd1;

    old_beat.run_color   = open_color_q;
    old_beat.run_length  = open_count_q;
    old_beat.frame_done  = 1'b0;
    old_beat.last_result = rle_enable_q && !in_q.frame_end;

    new_beat.run_color   = new_color;
    new_beat.run_length  = new_count;
    new_beat.frame_done  = in_q.frame_end;
    new_beat.last_result = 1'b1;

    push.beat0 = emit_old ? old_beat : new_beat;
    push.beat1 = new_beat;
    push.cnt   = fire ? {1'b0, emit_old} + {1'b0, emit_new} : 2'd0;
  end

  // run state update
  always_comb begin
    open_color_d = open_color_q;
    open_count_d = open_count_q;
    run_open_d   = run_open_q;
    if (fire) begin
      if (emit_new) begin
        open_color_d = 8'd0;
        open_count_d = 8'd0;
        run_open_d   = 1'b0;
      end else begin
        open_color_d = new_color;
        open_count_d = new_count;
        run_open_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_color_q <= 8'd0;
      open_count_q <= 8'd0;
      run_open_q   <= 1'b0;
    end else begin
      open_color_q <= open_color_d;
      open_count_q <= open_count_d;
      run_open_q   <= run_open_d;
    end
  end

  // result queue
  prle_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[design/prle_fifo.sv]
module prle_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  prle_pkg::push_t     push_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output prle_pkg::run_out_t  out_data_o
);

  prle_pkg::run_out_t                mem_q [prle_pkg::FifoDepth];
  logic [prle_pkg::PtrW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [prle_pkg::PtrW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [prle_pkg::CntW-1:0]         count_q, count_d;
  logic [prle_pkg::PtrW-1:0]         wr_ptr_nxt;
  logic                              pop;

  // room for two beats, judged on the registered fill only
  assign room_o      = count_q <= prle_pkg::CntW'(prle_pkg::FifoDepth - 2);
  assign out_valid_o = count_q != '0;
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign wr_ptr_nxt  = wr_ptr_q + prle_pkg::PtrW'(1);

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q + prle_pkg::PtrW'(push_i.cnt);
    rd_ptr_d = pop ? rd_ptr_q + prle_pkg::PtrW'(1) : rd_ptr_q;
    count_d  = count_q + prle_pkg::CntW'(push_i.cnt) - prle_pkg::CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, up to two beats written per cycle
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.beat0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_nxt] <= push_i.beat1;
    end
  end

endmodule

[design/prle_checker.sv]
module prle_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input prle_pkg::run_out_t  out_data_o
);

  // no result beat while reset is applied
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result beat during reset");

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // the end of a frame is always the last result of its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_done |-> out_data_o.last_result)
    else $error("frame_done without last_result");

  // a non-last result is followed at once by the rest of its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last_result |=> out_valid_o)
    else $error("second result of an item not ready");

  // no empty run is ever emitted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.run_length != 8'd0)
    else $error("zero run length");

endmodule

bind pixel_run_length_encoder prle_checker u_prle_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
